// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nda_pkg.sv =====
// ----------------------------------------------------------------------------
// nda_pkg
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nda_pkg;

    localparam int MAX_TARGETS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int OP_W            = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PEER  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec_load;
        logic exec_home;
        logic scan_init;
        logic mode_sel;
        logic scan_run;
        logic remove;
        logic out_load;
    } nda_cmd_t;

    typedef struct packed {
        logic op_load;
        logic op_peer;
        logic last_entry;
        logic count_zero;
        logic at_dest;
        logic is_mine;
        logic scan_last;
    } nda_stat_t;

endpackage

// ===== rtl/core/nda_ctrl.sv =====
// ----------------------------------------------------------------------------
// nda_ctrl
// Sequencer: accept, execute, table scan, remove, result hand-off.
// ----------------------------------------------------------------------------
module nda_ctrl
    import nda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  nda_stat_t stat,
    output nda_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_REMOVE = 5'b01000,
        S_FINISH = 5'b10000
    } nda_state_t;

    nda_state_t state_reg;
    nda_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.scan_init = 1'b1;
                cmd.exec_load = stat.op_load;
                cmd.exec_home = stat.op_peer && !stat.at_dest && stat.count_zero &&
                                stat.is_mine;
                if (stat.op_load && stat.last_entry)
                begin
                    cmd.mode_sel = 1'b1;
                    state_next   = S_SCAN;
                end
                else if (stat.op_peer && !stat.at_dest && !stat.count_zero)
                begin
                    cmd.mode_sel = stat.is_mine;
                    state_next   = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/nda_dp.sv =====
// ----------------------------------------------------------------------------
// nda_dp
// Destination table memory, scan unit, destination/origin state and result
// registers.
// ----------------------------------------------------------------------------
module nda_dp
    import nda_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_TARGETS + 1),
    parameter int IDX_W       = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nda_cmd_t                     cmd,
    output nda_stat_t                    stat,
    input  logic        [OP_W-1:0]       operation,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                         first_entry,
    input  logic                         last_entry,
    output logic signed [COORD_BITS-1:0] dest_x,
    output logic signed [COORD_BITS-1:0] dest_z,
    output logic                         arrived,
    output logic        [CNT_W-1:0]      remaining,
    output logic                         overflow
);

    localparam int CB = COORD_BITS;

    logic [2*CB-1:0] mem [MAX_TARGETS];

    // captured request
    logic [OP_W-1:0]  op_reg;
    logic [CB-1:0]    qx_reg;
    logic [CB-1:0]    qz_reg;
    logic [CB-1:0]    px_reg;
    logic [CB-1:0]    pz_reg;
    logic             first_reg;
    logic             last_reg;

    // block state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CB-1:0]    dst_x_reg;
    logic [CB-1:0]    dst_x_next;
    logic [CB-1:0]    dst_z_reg;
    logic [CB-1:0]    dst_z_next;
    logic [CB-1:0]    org_x_reg;
    logic [CB-1:0]    org_z_reg;
    logic             ovf_reg;

    // scan unit
    logic             mode_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic [2*CB-1:0]  rd_data_reg;
    logic [CNT_W-1:0] cmp_idx_reg;
    logic [CB+1:0]    best_d_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [2*CB-1:0]  best_data_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             found_reg;
    logic [2*CB-1:0]  tail_data_reg;

    // result registers
    logic [CB-1:0]    res_x_reg;
    logic [CB-1:0]    res_z_reg;
    logic             res_arr_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic             res_ovf_reg;

    logic [CNT_W-1:0] load_idx;
    logic             full;
    logic             rd_issue;
    logic             proc;
    logic [CB-1:0]    rx;
    logic [CB-1:0]    rz;
    logic [CB:0]      dx;
    logic [CB:0]      dz;
    logic [CB:0]      adx;
    logic [CB:0]      adz;
    logic [CB+1:0]    cand_d;
    logic             better;
    logic             match;
    logic             rm_en;
    logic [IDX_W-1:0] rm_slot;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [2*CB-1:0]  wr_data;

    assign load_idx = first_reg ? '0 : count_reg;
    assign full     = (load_idx == CNT_W'(MAX_TARGETS));
    assign rd_issue = cmd.scan_run && (rd_idx_reg < count_reg);
    assign proc     = cmd.scan_run && rd_vld_reg;

    assign rx  = rd_data_reg[2*CB-1:CB];
    assign rz  = rd_data_reg[CB-1:0];
    assign dx  = {rx[CB-1], rx} - {px_reg[CB-1], px_reg};
    assign dz  = {rz[CB-1], rz} - {pz_reg[CB-1], pz_reg};
    assign adx = dx[CB] ? (~dx + 1'b1) : dx;
    assign adz = dz[CB] ? (~dz + 1'b1) : dz;
    assign cand_d = {1'b0, adx} + {1'b0, adz};

    assign better = (cmp_idx_reg == '0) || (cand_d < best_d_reg);
    assign match  = (rx == qx_reg) && (rz == qz_reg);

    assign rm_en   = cmd.remove && (mode_reg || found_reg);
    assign rm_slot = mode_reg ? best_idx_reg : hit_idx_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = load_idx[IDX_W-1:0];
        wr_data = {qx_reg, qz_reg};
        if (cmd.exec_load && !full)
        begin
            wr_en = 1'b1;
        end
        else if (rm_en)
        begin
            wr_en   = 1'b1;
            wr_addr = rm_slot;
            wr_data = tail_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            qx_reg    <= point_x;
            qz_reg    <= point_z;
            px_reg    <= pos_x;
            pz_reg    <= pos_z;
            first_reg <= first_entry;
            last_reg  <= last_entry;
        end
        if (cmd.scan_init)
        begin
            mode_reg <= cmd.mode_sel;
        end
        if (proc)
        begin
            tail_data_reg <= rd_data_reg;
            if (better)
            begin
                best_d_reg    <= cand_d;
                best_idx_reg  <= cmp_idx_reg[IDX_W-1:0];
                best_data_reg <= rd_data_reg;
            end
            if (match)
            begin
                hit_idx_reg <= cmp_idx_reg[IDX_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            res_x_reg   <= dst_x_reg;
            res_z_reg   <= dst_z_reg;
            res_arr_reg <= (px_reg == dst_x_reg) && (pz_reg == dst_z_reg);
            res_cnt_reg <= count_reg;
            res_ovf_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        dst_x_next = dst_x_reg;
        dst_z_next = dst_z_reg;
        if (cmd.exec_load)
        begin
            count_next = full ? load_idx : load_idx + 1'b1;
        end
        else if (rm_en)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.exec_home)
        begin
            dst_x_next = org_x_reg;
            dst_z_next = org_z_reg;
        end
        else if (cmd.remove && mode_reg)
        begin
            dst_x_next = best_data_reg[2*CB-1:CB];
            dst_z_next = best_data_reg[CB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dst_x_reg   <= '1;
            dst_z_reg   <= '1;
            org_x_reg   <= '0;
            org_z_reg   <= '0;
            ovf_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            cmp_idx_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dst_x_reg <= dst_x_next;
            dst_z_reg <= dst_z_next;
            if (cmd.capture)
            begin
                ovf_reg <= 1'b0;
            end
            else if (cmd.exec_load)
            begin
                ovf_reg <= full;
            end
            if (cmd.exec_load && first_reg)
            begin
                org_x_reg <= px_reg;
                org_z_reg <= pz_reg;
            end
            if (cmd.scan_init)
            begin
                rd_idx_reg  <= '0;
                rd_vld_reg  <= 1'b0;
                cmp_idx_reg <= '0;
                found_reg   <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                rd_vld_reg <= rd_issue;
                if (rd_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (proc)
                begin
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                    if (match)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign stat.op_load    = (op_reg == OP_LOAD);
    assign stat.op_peer    = (op_reg == OP_PEER);
    assign stat.last_entry = last_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.at_dest    = (px_reg == dst_x_reg) && (pz_reg == dst_z_reg);
    assign stat.is_mine    = (qx_reg == dst_x_reg) && (qz_reg == dst_z_reg);
    assign stat.scan_last  = proc && (cmp_idx_reg == count_reg - 1'b1);

    assign dest_x    = res_x_reg;
    assign dest_z    = res_z_reg;
    assign arrived   = res_arr_reg;
    assign remaining = res_cnt_reg;
    assign overflow  = res_ovf_reg;

endmodule

// ===== rtl/core/nearest_destination_allocator.sv =====
// ----------------------------------------------------------------------------
// nearest_destination_allocator
// Keeps a table of grid destinations and hands out the nearest one.
//
// Input channel (in_valid/in_ready) carries one request: load an entry,
// report a peer arrival, or query. Output channel (out_valid/out_ready)
// returns one status per request: destination, arrived, remaining, overflow.
// Requests are handled one at a time. A scan (nearest selection or peer
// match removal) reads the table memory through its single read port, one
// entry per cycle, before the status is loaded. The next request is
// accepted in the cycle after the status is loaded. in_ready is high
// whenever no request is in progress, also while a finished status waits
// in the output register. If the receiver stalls, the next request is
// processed up to its hand-off and then holds until the output register
// frees. Reset empties the table, sets the destination to minus one and
// the origin to zero.
// ----------------------------------------------------------------------------
module nearest_destination_allocator
    import nda_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic        [OP_W-1:0]                  operation,
    input  logic signed [COORD_BITS-1:0]            point_x,
    input  logic signed [COORD_BITS-1:0]            point_z,
    input  logic signed [COORD_BITS-1:0]            pos_x,
    input  logic signed [COORD_BITS-1:0]            pos_z,
    input  logic                                    first_entry,
    input  logic                                    last_entry,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [COORD_BITS-1:0]            dest_x,
    output logic signed [COORD_BITS-1:0]            dest_z,
    output logic                                    arrived,
    output logic        [$clog2(MAX_TARGETS+1)-1:0] remaining,
    output logic                                    overflow
);

    nda_cmd_t  cmd;
    nda_stat_t stat;

    nda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nda_dp #(
        .MAX_TARGETS (MAX_TARGETS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .point_x     (point_x),
        .point_z     (point_z),
        .pos_x       (pos_x),
        .pos_z       (pos_z),
        .first_entry (first_entry),
        .last_entry  (last_entry),
        .dest_x      (dest_x),
        .dest_z      (dest_z),
        .arrived     (arrived),
        .remaining   (remaining),
        .overflow    (overflow)
    );

endmodule

// ===== rtl/core/nda_checker.sv =====
// ----------------------------------------------------------------------------
// nda_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nda_checker
    import nda_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [COORD_BITS-1:0]            dest_x,
    input logic signed [COORD_BITS-1:0]            dest_z,
    input logic                                    arrived,
    input logic        [$clog2(MAX_TARGETS+1)-1:0] remaining,
    input logic                                    overflow
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dest_x) && $stable(dest_z) && $stable(remaining) && $stable(overflow) && $stable(arrived), "status changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while busy")
    `ASSERT_IMPLIES(a_remaining_range, clk, rst_n, out_valid, int'(remaining) <= MAX_TARGETS, "remaining beyond capacity")
    `ASSERT_IMPLIES(a_overflow_full, clk, rst_n, out_valid && overflow, int'(remaining) + 1 >= MAX_TARGETS, "overflow without full table")

endmodule

bind nearest_destination_allocator nda_checker #(
    .MAX_TARGETS (MAX_TARGETS),
    .COORD_BITS  (COORD_BITS)
) u_nda_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for nearest_destination_allocator. A short table
// of directed requests (reset state, coordinate extremes, ties, duplicate
// entries, peer reports in every table state) is followed by random load
// sequences, peer reports and queries. Every status is compared with an
// in-bench table model or a fixed directed expectation; both channels idle
// at random and the receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
    import nda_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int MT          = MAX_TARGETS_DEF;
    localparam int RW          = $clog2(MT + 1);
    localparam int CLK_PERIOD  = 10;
    localparam int RANDOM_REQS = 400;
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = MT + 20;
    localparam int CHOKE_LEN   = 400;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        coord_t          qx;
        coord_t          qz;
        coord_t          px;
        coord_t          pz;
        logic            first;
        logic            last;
    } req_t;

    typedef struct packed {
        coord_t          dx;
        coord_t          dz;
        logic            arr;
        logic [RW-1:0]   rem;
        logic            ovf;
    } status_t;

    typedef struct {
        req_t    req;
        bit      typed;
        status_t want;
    } dir_row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [OP_W-1:0] operation;
    coord_t          point_x;
    coord_t          point_z;
    coord_t          pos_x;
    coord_t          pos_z;
    logic            first_entry;
    logic            last_entry;
    logic            out_valid;
    logic            out_ready;
    coord_t          dest_x;
    coord_t          dest_z;
    logic            arrived;
    logic [RW-1:0]   remaining;
    logic            overflow;

    nearest_destination_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .point_x     (point_x),
        .point_z     (point_z),
        .pos_x       (pos_x),
        .pos_z       (pos_z),
        .first_entry (first_entry),
        .last_entry  (last_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_x      (dest_x),
        .dest_z      (dest_z),
        .arrived     (arrived),
        .remaining   (remaining),
        .overflow    (overflow)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // destination table model
    coord_t   tab_x [MT];
    coord_t   tab_z [MT];
    int       n_entries = 0;
    coord_t   goal_x    = '1;
    coord_t   goal_z    = '1;
    coord_t   home_x    = '0;
    coord_t   home_z    = '0;

    status_t  status_due [$];
    dir_row_t dir_rows [$];

    int errors       = 0;
    int reported     = 0;
    int n_sent       = 0;
    int n_loads      = 0;
    int n_peers      = 0;
    int n_queries    = 0;
    int results_seen = 0;
    int n_ovf_seen   = 0;
    int n_arr_seen   = 0;
    int cycle_count  = 0;
    bit calm_tx      = 1'b0;

    function automatic int manhattan(coord_t ax, coord_t az, coord_t bx, coord_t bz);
        int dx;
        int dz;
        dx = int'(ax) - int'(bx);
        dz = int'(az) - int'(bz);
        if (dx < 0) dx = -dx;
        if (dz < 0) dz = -dz;
        return dx + dz;
    endfunction

    function automatic void drop_slot(int slot);
        if (slot < n_entries)
        begin
            tab_x[slot] = tab_x[n_entries - 1];
            tab_z[slot] = tab_z[n_entries - 1];
            n_entries--;
        end
    endfunction

    function automatic void take_nearest(coord_t px, coord_t pz);
        int best;
        int best_d;
        int d;
        if (n_entries == 0)
            return;
        best   = 0;
        best_d = manhattan(tab_x[0], tab_z[0], px, pz);
        for (int i = 1; i < n_entries; i++)
        begin
            d = manhattan(tab_x[i], tab_z[i], px, pz);
            if (d < best_d)
            begin
                best_d = d;
                best   = i;
            end
        end
        goal_x = tab_x[best];
        goal_z = tab_z[best];
        drop_slot(best);
    endfunction

    function automatic status_t predict_status(req_t r);
        status_t s;
        bit      at_goal;
        bit      mine;
        int      hit;
        s.ovf = 1'b0;
        case (r.op)
            OP_LOAD:
            begin
                if (r.first)
                begin
                    n_entries = 0;
                    home_x    = r.px;
                    home_z    = r.pz;
                end
                if (n_entries < MT)
                begin
                    tab_x[n_entries] = r.qx;
                    tab_z[n_entries] = r.qz;
                    n_entries++;
                end
                else
                    s.ovf = 1'b1;
                if (r.last)
                    take_nearest(r.px, r.pz);
            end
            OP_PEER:
            begin
                at_goal = (r.px == goal_x) && (r.pz == goal_z);
                mine    = (r.qx == goal_x) && (r.qz == goal_z);
                if (!at_goal)
                begin
                    if (n_entries > 0)
                    begin
                        if (mine)
                            take_nearest(r.px, r.pz);
                        else
                        begin
                            hit = -1;
                            for (int i = 0; i < n_entries; i++)
                                if (tab_x[i] == r.qx && tab_z[i] == r.qz)
                                    hit = i;
                            if (hit >= 0)
                                drop_slot(hit);
                        end
                    end
                    else if (mine)
                    begin
                        goal_x = home_x;
                        goal_z = home_z;
                    end
                end
            end
            default: ;
        endcase
        s.dx  = goal_x;
        s.dz  = goal_z;
        s.arr = (r.px == goal_x) && (r.pz == goal_z);
        s.rem = RW'(n_entries);
        return s;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic coord_t rand_coord(bit near);
        return near ? coord_t'(int'($urandom_range(0, 40)) - 20) : coord_t'($urandom());
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, int qx, int qz, int px, int pz,
                                    bit f = 0, bit l = 0, bit typed = 0,
                                    int edx = 0, int edz = 0, bit earr = 0, int erem = 0);
        dir_row_t row;
        row.req.op    = op;
        row.req.qx    = coord_t'(qx);
        row.req.qz    = coord_t'(qz);
        row.req.px    = coord_t'(px);
        row.req.pz    = coord_t'(pz);
        row.req.first = f;
        row.req.last  = l;
        row.typed     = typed;
        row.want.dx   = coord_t'(edx);
        row.want.dz   = coord_t'(edz);
        row.want.arr  = earr;
        row.want.rem  = RW'(erem);
        row.want.ovf  = 1'b0;
        dir_rows.push_back(row);
    endfunction

    task automatic offer_request(req_t r);
        int gap;
        gap = calm_tx ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= r.op;
        point_x     <= r.qx;
        point_z     <= r.qz;
        pos_x       <= r.px;
        pos_z       <= r.pz;
        first_entry <= r.first;
        last_entry  <= r.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
        case (r.op)
            OP_LOAD: n_loads++;
            OP_PEER: n_peers++;
            default: n_queries++;
        endcase
    endtask

    task automatic send_predicted(req_t r);
        offer_request(r);
        status_due.push_back(predict_status(r));
    endtask

    // status checker and receiver idling
    initial
    begin
        status_t got;
        status_t want;
        int      rx_pause;
        bit      choke_done;
        rx_pause   = 0;
        choke_done = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.dx  = dest_x;
                got.dz  = dest_z;
                got.arr = arrived;
                got.rem = remaining;
                got.ovf = overflow;
                results_seen++;
                if (got.ovf === 1'b1) n_ovf_seen++;
                if (got.arr === 1'b1) n_arr_seen++;
                if (status_due.size() == 0)
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("ERROR: unexpected status dest=(%0d,%0d) arr=%0b rem=%0d ovf=%0b",
                                 got.dx, got.dz, got.arr, got.rem, got.ovf);
                    end
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.dx !== want.dx || got.dz !== want.dz || got.arr !== want.arr ||
                        got.rem !== want.rem || got.ovf !== want.ovf)
                    begin
                        errors++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("ERROR: status %0d expected dest=(%0d,%0d) arr=%0b rem=%0d ovf=%0b",
                                     results_seen, want.dx, want.dz, want.arr, want.rem, want.ovf);
                            $display("       got dest=(%0d,%0d) arr=%0b rem=%0d ovf=%0b",
                                     got.dx, got.dz, got.arr, got.rem, got.ovf);
                        end
                    end
                end
            end
            // hold off once so the input backs up
            if (!choke_done && results_seen >= 120)
            begin
                choke_done = 1'b1;
                rx_pause   = CHOKE_LEN;
            end
            if (rx_pause > 0)
            begin
                out_ready <= 1'b0;
                rx_pause--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (results_seen < 260 || results_seen >= 330)
                    rx_pause = idle_len();
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        req_t    r;
        status_t s;
        int      len;
        int      pick;
        int      kind;
        bit      near;
        bit      broken;
        coord_t  sx;
        coord_t  sz;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_QUERY;
        point_x     = '0;
        point_z     = '0;
        pos_x       = '0;
        pos_z       = '0;
        first_entry = 1'b0;
        last_entry  = 1'b0;

        add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, -1, -1, 0, 0);
        add_row(OP_QUERY, 0, 0, -1, -1, 1, 1, 1, -1, -1, 1, 0);
        add_row(OP_SPARE, 9, 9, 3, 3, 1, 0, 1, -1, -1, 0, 0);
        add_row(OP_PEER, -1, -1, -1, -1, 0, 0, 1, -1, -1, 1, 0);
        add_row(OP_PEER, 7, 7, 5, 5, 0, 0, 1, -1, -1, 0, 0);
        add_row(OP_PEER, -1, -1, 5, 5, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_LOAD, 32767, -32768, 100, 200, 1, 0, 1, 0, 0, 0, 1);
        add_row(OP_LOAD, -32768, 32767, 100, 200);
        add_row(OP_LOAD, 100, 200, 100, 200);
        add_row(OP_LOAD, -32768, -32768, 100, 200, 0, 1, 1, 100, 200, 1, 3);
        add_row(OP_PEER, 32767, -32768, 100, 200);
        add_row(OP_PEER, 32767, -32768, 0, 0);
        add_row(OP_PEER, 1, 1, 0, 0);
        add_row(OP_PEER, 100, 200, -32768, -32768);
        add_row(OP_LOAD, 10, 0, 0, 0, 1, 0);
        add_row(OP_LOAD, 0, 10, 0, 0);
        add_row(OP_LOAD, -5, -5, 0, 0, 0, 1, 1, 10, 0, 0, 2);
        add_row(OP_PEER, 10, 0, 0, 0, 0, 0, 1, -5, -5, 0, 1);
        add_row(OP_PEER, 0, 10, 0, 0, 0, 0, 1, -5, -5, 0, 0);
        add_row(OP_PEER, -5, -5, 1, 1, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_LOAD, 32767, 32767, -32768, -32768, 1, 1);
        add_row(OP_PEER, 32767, 32767, 0, 0);
        add_row(OP_LOAD, 4, 4, 6, 6, 1, 0);
        add_row(OP_LOAD, 4, 4, 6, 6);
        add_row(OP_LOAD, 9, 9, 6, 6);
        add_row(OP_PEER, 4, 4, 6, 6);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            offer_request(dir_rows[i].req);
            s = predict_status(dir_rows[i].req);
            status_due.push_back(dir_rows[i].typed ? dir_rows[i].want : s);
        end

        while (n_sent < dir_rows.size() + RANDOM_REQS)
        begin
            calm_tx = (n_sent >= 200 && n_sent < 260);
            kind    = $urandom_range(0, 99);
            near    = ($urandom_range(0, 2) != 0);
            if (kind < 45)
            begin
                len    = ($urandom_range(0, 24) == 0) ? $urandom_range(MT, MT + 6)
                                                      : $urandom_range(1, 8);
                broken = ($urandom_range(0, 9) == 0);
                sx     = rand_coord(near);
                sz     = rand_coord(near);
                for (int k = 0; k < len; k++)
                begin
                    r.op    = OP_LOAD;
                    r.qx    = rand_coord(near);
                    r.qz    = rand_coord(near);
                    r.px    = sx;
                    r.pz    = sz;
                    r.first = (k == 0);
                    r.last  = (k == len - 1);
                    if (broken && $urandom_range(0, 1) == 1)
                    begin
                        r.first = 1'($urandom_range(0, 1));
                        r.last  = 1'($urandom_range(0, 1));
                    end
                    send_predicted(r);
                end
            end
            else if (kind < 75)
            begin
                r.op   = OP_PEER;
                pick   = $urandom_range(0, 9);
                if (n_entries > 0 && pick < 4)
                begin
                    len  = $urandom_range(0, n_entries - 1);
                    r.qx = tab_x[len];
                    r.qz = tab_z[len];
                end
                else if (pick < 7)
                begin
                    r.qx = goal_x;
                    r.qz = goal_z;
                end
                else
                begin
                    r.qx = rand_coord(near);
                    r.qz = rand_coord(near);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    r.px = goal_x;
                    r.pz = goal_z;
                end
                else
                begin
                    r.px = rand_coord(near);
                    r.pz = rand_coord(near);
                end
                r.first = 1'($urandom_range(0, 1));
                r.last  = 1'($urandom_range(0, 1));
                send_predicted(r);
            end
            else
            begin
                r.op    = (kind < 90) ? OP_QUERY : ($urandom_range(0, 1) ? OP_SPARE : OP_LOAD);
                r.qx    = rand_coord(near);
                r.qz    = rand_coord(near);
                if ($urandom_range(0, 2) == 0)
                begin
                    r.px = goal_x;
                    r.pz = goal_z;
                end
                else
                begin
                    r.px = rand_coord(near);
                    r.pz = rand_coord(near);
                end
                r.first = 1'($urandom_range(0, 1));
                r.last  = 1'($urandom_range(0, 1));
                send_predicted(r);
            end
        end
        in_valid <= 1'b0;

        while (status_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d loads, %0d peer reports, %0d queries) in %0d cycles;",
                 n_sent, n_loads, n_peers, n_queries, cycle_count);
        $display("%0d statuses checked, %0d with overflow, %0d arrived, %0d errors.",
                 results_seen, n_ovf_seen, n_arr_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
